/* src/svmix_pkg.sv */
package svmix_pkg;

    // item operation codes
    typedef enum logic [1:0] {
        OP_TICK      = 2'd0,
        OP_WR_SAMPLE = 2'd1,
        OP_WR_VOICE  = 2'd2,
        OP_START     = 2'd3
    } t_opcode;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCHED_START  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCHED_FRAMES = 1'b1;

    // fixed field widths
    localparam int TIME_W   = 32;
    localparam int TL_W     = 33;
    localparam int BASE_W   = 16;
    localparam int CLIPSZ_W = 17;
    localparam int WIDE_W   = 36;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WIN,
        S_REL,
        S_IDX,
        S_MUL,
        S_ACC,
        S_OUT
    } t_state;

endpackage

/* src/svmix_in_if.sv */
interface svmix_in_if #(
    parameter int SAMPLE_BITS = 16,
    parameter int GAIN_BITS   = 16
);
    logic                          valid;
    logic                          ready;
    logic [1:0]                    opcode;
    logic [15:0]                   sample_address;
    logic signed [SAMPLE_BITS-1:0] sample_value;
    logic [2:0]                    voice_index;
    logic                          voice_enable;
    logic signed [31:0]            voice_render_start;
    logic [31:0]                   voice_frames;
    logic signed [31:0]            voice_clip_offset;
    logic [15:0]                   voice_clip_base;
    logic [16:0]                   voice_clip_length;
    logic signed [GAIN_BITS-1:0]   voice_gain_left;
    logic signed [GAIN_BITS-1:0]   voice_gain_right;

    modport source (
        output valid, opcode, sample_address, sample_value, voice_index, voice_enable,
               voice_render_start, voice_frames, voice_clip_offset, voice_clip_base,
               voice_clip_length, voice_gain_left, voice_gain_right,
        input  ready
    );
    modport sink (
        input  valid, opcode, sample_address, sample_value, voice_index, voice_enable,
               voice_render_start, voice_frames, voice_clip_offset, voice_clip_base,
               voice_clip_length, voice_gain_left, voice_gain_right,
        output ready
    );
endinterface

/* src/svmix_out_if.sv */
interface svmix_out_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_sample;
    logic signed [SAMPLE_BITS-1:0] right_sample;
    logic                          playing;

    modport source (output valid, left_sample, right_sample, playing, input ready);
    modport sink   (input  valid, left_sample, right_sample, playing, output ready);
endinterface

/* src/svmix_ram.sv */
module svmix_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* src/svmix_sat.sv */
module svmix_sat #(
    parameter int ACC_W       = 39,
    parameter int SAMPLE_BITS = 16,
    parameter int SHIFT       = 14
) (
    input  logic signed [ACC_W-1:0]       i_acc,
    output logic signed [SAMPLE_BITS-1:0] o_sample
);
    localparam logic signed [ACC_W:0] HALF = (ACC_W+1)'(1) <<< (SHIFT - 1);
    localparam logic signed [ACC_W:0] HI   = (ACC_W+1)'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [ACC_W:0] LO   = -HI - (ACC_W+1)'(1);

    logic signed [ACC_W:0] sum;
    logic signed [ACC_W:0] shr;

    // round half up, then clamp
    always_comb begin
        sum = (ACC_W+1)'(i_acc) + HALF;
        shr = sum >>> SHIFT;
        if (shr > HI) begin
            o_sample = HI[SAMPLE_BITS-1:0];
        end else if (shr < LO) begin
            o_sample = LO[SAMPLE_BITS-1:0];
        end else begin
            o_sample = shr[SAMPLE_BITS-1:0];
        end
    end
endmodule

/* src/scheduled_voice_sample_mixer.sv */
// Write-sample, write-voice and start items finish in S_IDLE. One item is worked on at a time.
// A tick goes to S_WIN, then S_REL, S_IDX, S_MUL and S_ACC for each voice, then S_OUT; when
// stopped it goes straight to S_OUT, out of window from S_WIN to S_OUT. S_OUT holds while the
// result waits on o_result.ready. A voice walks descriptor read, window test, sample RAM read,
// multiply and accumulate. Reset (synchronous, active low) stops playback, clears voice
// enables, timeline, config registers and the output slot. Sample memory is not cleared.
module scheduled_voice_sample_mixer
    import svmix_pkg::*;
#(
    parameter int MAX_VOICES   = 8,
    parameter int SAMPLE_DEPTH = 65536,
    parameter int SAMPLE_BITS  = 16,
    parameter int GAIN_BITS    = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    svmix_in_if.sink             i_item,
    svmix_out_if.source          o_result,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [TIME_W-1:0]    i_cfg_data
);
    localparam int AW    = $clog2(SAMPLE_DEPTH);
    localparam int VW    = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
    localparam int PW    = SAMPLE_BITS + GAIN_BITS;
    localparam int ACC_W = PW + 7;
    localparam int SHIFT = GAIN_BITS - 2;

    // descriptor layout, low to high
    localparam int D_START = 0;
    localparam int D_LEN   = D_START + TIME_W;
    localparam int D_CLIP  = D_LEN + TIME_W;
    localparam int D_BASE  = D_CLIP + TIME_W;
    localparam int D_SIZE  = D_BASE + BASE_W;
    localparam int D_GL    = D_SIZE + CLIPSZ_W;
    localparam int D_GR    = D_GL + GAIN_BITS;
    localparam int DW      = D_GR + GAIN_BITS;

    t_state r_state, n_state;

    // config and playback state
    logic [TIME_W-1:0]     r_sched_start;
    logic [TIME_W-1:0]     r_sched_frames;
    logic [TL_W-1:0]       r_timeline;
    logic                  r_running;
    logic [MAX_VOICES-1:0] r_voice_on;

    // tick working registers
    logic                    r_live;      // tick while running
    logic signed [WIDE_W-1:0] r_off;
    logic [VW:0]             r_vi;
    logic                    r_hit;
    logic signed [WIDE_W-1:0] r_rel;
    logic                    r_hit2;
    logic signed [GAIN_BITS-1:0] r_gl, r_gr;
    logic signed [PW-1:0]    r_pl, r_pr;
    logic signed [ACC_W-1:0] r_accl, r_accr;

    // output slot
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_left, r_right;
    logic                          r_play;

    logic accept;
    logic slot_free;
    logic last_voice;
    logic in_win;

    // RAM hookup
    logic                  smp_we;
    logic [AW-1:0]         smp_waddr, smp_raddr;
    logic [SAMPLE_BITS-1:0] smp_rdata;
    logic                  desc_we;
    logic [VW-1:0]         desc_waddr;
    logic [DW-1:0]         desc_wdata, desc_rdata;
    logic [39:0]           waddr_ext;
    logic [6:0]            vidx_ext;
    logic                  vidx_ok;

    // decoded descriptor
    logic signed [WIDE_W-1:0] d_start, d_len, d_clip, d_size, d_base;
    logic signed [WIDE_W-1:0] rel, idx, saddr_sum;
    logic signed [SAMPLE_BITS-1:0] smp;
    logic signed [SAMPLE_BITS-1:0] mix_l, mix_r;
    logic [TL_W-1:0] tl_next;
    logic [TL_W-1:0] sched_end;

    assign accept     = i_item.valid && i_item.ready;
    assign slot_free  = !r_out_valid || o_result.ready;
    // r_vi has already stepped past the voice being accumulated
    assign last_voice = (r_vi == (VW+1)'(MAX_VOICES));
    assign in_win     = !r_off[WIDE_W-1] && (r_off < {4'd0, r_sched_frames});

    assign waddr_ext = {24'd0, i_item.sample_address};
    assign smp_waddr = waddr_ext[AW-1:0];
    assign vidx_ext  = {4'd0, i_item.voice_index};
    assign vidx_ok   = ({29'd0, i_item.voice_index} < 32'(MAX_VOICES));
    assign desc_waddr = vidx_ext[VW-1:0];
    assign desc_wdata = {i_item.voice_gain_right, i_item.voice_gain_left,
                         i_item.voice_clip_length, i_item.voice_clip_base,
                         i_item.voice_clip_offset, i_item.voice_frames,
                         i_item.voice_render_start};

    assign d_start = WIDE_W'(signed'(desc_rdata[D_LEN-1:D_START]));
    assign d_len   = {4'd0, desc_rdata[D_CLIP-1:D_LEN]};
    assign d_clip  = WIDE_W'(signed'(desc_rdata[D_BASE-1:D_CLIP]));
    assign d_base  = {20'd0, desc_rdata[D_SIZE-1:D_BASE]};
    assign d_size  = {19'd0, desc_rdata[D_GL-1:D_SIZE]};

    assign rel       = r_off - d_start;
    assign idx       = d_clip + r_rel;
    assign saddr_sum = d_base + idx;
    assign smp_raddr = saddr_sum[AW-1:0];
    assign smp       = signed'(smp_rdata);

    assign tl_next   = r_timeline + TL_W'(1);
    assign sched_end = {1'b0, r_sched_start} + {1'b0, r_sched_frames};

    svmix_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(SAMPLE_DEPTH)) u_smp_ram (
        .i_clk  (i_clk),
        .i_we   (smp_we),
        .i_waddr(smp_waddr),
        .i_wdata(i_item.sample_value),
        .i_raddr(smp_raddr),
        .o_rdata(smp_rdata)
    );

    svmix_ram #(.WIDTH(DW), .DEPTH(1 << VW)) u_desc_ram (
        .i_clk  (i_clk),
        .i_we   (desc_we),
        .i_waddr(desc_waddr),
        .i_wdata(desc_wdata),
        .i_raddr(r_vi[VW-1:0]),
        .o_rdata(desc_rdata)
    );

    svmix_sat #(.ACC_W(ACC_W), .SAMPLE_BITS(SAMPLE_BITS), .SHIFT(SHIFT)) u_sat_l (
        .i_acc(r_accl), .o_sample(mix_l)
    );
    svmix_sat #(.ACC_W(ACC_W), .SAMPLE_BITS(SAMPLE_BITS), .SHIFT(SHIFT)) u_sat_r (
        .i_acc(r_accr), .o_sample(mix_r)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && t_opcode'(i_item.opcode) == OP_TICK) begin
                    n_state = r_running ? S_WIN : S_OUT;
                end
            end
            S_WIN:   n_state = in_win ? S_REL : S_OUT;
            S_REL:   n_state = S_IDX;
            S_IDX:   n_state = S_MUL;
            S_MUL:   n_state = S_ACC;
            S_ACC:   n_state = last_voice ? S_OUT : S_REL;
            S_OUT:   n_state = slot_free ? S_IDLE : S_OUT;
            default: n_state = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        i_item.ready = (r_state == S_IDLE);
        smp_we  = accept && t_opcode'(i_item.opcode) == OP_WR_SAMPLE;
        desc_we = accept && t_opcode'(i_item.opcode) == OP_WR_VOICE && vidx_ok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // config port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sched_start  <= '0;
            r_sched_frames <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SCHED_START:  r_sched_start  <= i_cfg_data;
                CFG_SCHED_FRAMES: r_sched_frames <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // control state: enables, timeline, run flag, output slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_voice_on  <= '0;
            r_timeline  <= '0;
            r_running   <= 1'b0;
            r_out_valid <= 1'b0;
            r_live      <= 1'b0;
            r_vi        <= '0;
        end else begin
            if (r_out_valid && o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_vi <= '0;
                    if (accept) begin
                        case (t_opcode'(i_item.opcode))
                            OP_WR_VOICE: begin
                                if (vidx_ok) begin
                                    r_voice_on[desc_waddr] <= i_item.voice_enable;
                                end
                            end
                            OP_START: begin
                                if (r_sched_frames == '0 || r_voice_on == '0) begin
                                    r_running <= 1'b0;
                                end else begin
                                    r_timeline <= {1'b0, r_sched_start};
                                    r_running  <= 1'b1;
                                end
                            end
                            OP_TICK: r_live <= r_running;
                            default: ;
                        endcase
                    end
                end
                S_MUL: r_vi <= r_vi + (VW+1)'(1);
                S_OUT: begin
                    if (slot_free) begin
                        r_out_valid <= 1'b1;
                        if (r_live) begin
                            r_timeline <= tl_next;
                            if (tl_next >= sched_end) begin
                                r_running <= 1'b0;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_off  <= WIDE_W'(r_timeline) - WIDE_W'(r_sched_start);
                r_accl <= '0;
                r_accr <= '0;
            end
            S_REL: begin
                // in voice window when 0 <= rel < length
                r_rel <= rel;
                r_hit <= r_voice_on[r_vi[VW-1:0]] && !rel[WIDE_W-1] && (rel < d_len);
                r_gl  <= signed'(desc_rdata[D_GR-1:D_GL]);
                r_gr  <= signed'(desc_rdata[DW-1:D_GR]);
            end
            S_IDX: begin
                r_hit2 <= r_hit && !idx[WIDE_W-1] && (idx < d_size);
            end
            S_MUL: begin
                r_pl <= r_hit2 ? PW'(smp) * PW'(r_gl) : '0;
                r_pr <= r_hit2 ? PW'(smp) * PW'(r_gr) : '0;
            end
            S_ACC: begin
                r_accl <= r_accl + ACC_W'(r_pl);
                r_accr <= r_accr + ACC_W'(r_pr);
            end
            S_OUT: begin
                if (slot_free) begin
                    r_left  <= r_live ? mix_l : '0;
                    r_right <= r_live ? mix_r : '0;
                    r_play  <= r_live && (tl_next < sched_end);
                end
            end
            default: ;
        endcase
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.left_sample  = r_left;
    assign o_result.right_sample = r_right;
    assign o_result.playing      = r_play;
endmodule

/* src/svmix_checker.sv */
module svmix_checker
    import svmix_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   i_in_ready,
    input logic [1:0]             i_in_opcode,
    input logic                   i_out_valid,
    input logic                   i_out_ready,
    input logic [SAMPLE_BITS-1:0] i_out_left,
    input logic [SAMPLE_BITS-1:0] i_out_right,
    input logic                   i_out_playing
);
    // reset empties the output slot
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // a tick keeps the block busy: no item is taken right after it
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_opcode == OP_TICK |=> !i_in_ready)
        else $error("item taken right after a tick");

    // writes and start leave the input ready for the next item
    a_fast_ops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_opcode != OP_TICK |=> i_in_ready)
        else $error("single cycle item stalled");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_left)
            && $stable(i_out_right) && $stable(i_out_playing))
        else $error("stalled result changed");
endmodule

bind scheduled_voice_sample_mixer svmix_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_svmix_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_item.valid),
    .i_in_ready   (i_item.ready),
    .i_in_opcode  (i_item.opcode),
    .i_out_valid  (o_result.valid),
    .i_out_ready  (o_result.ready),
    .i_out_left   (o_result.left_sample),
    .i_out_right  (o_result.right_sample),
    .i_out_playing(o_result.playing)
);

/* verif/scheduled_voice_sample_mixer_test.sv */
module scheduled_voice_sample_mixer_test;
    import svmix_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NVOICE   = 8;
    localparam int MEM_BITS = 16;
    localparam int LIMIT    = 2_000_000;

    // one input item as driven on the channel
    typedef struct packed {
        t_opcode            op;
        logic [15:0]        addr;
        logic signed [15:0] value;
        logic [2:0]         vidx;
        logic               ven;
        logic signed [31:0] vstart;
        logic [31:0]        vframes;
        logic signed [31:0] voffs;
        logic [15:0]        vbase;
        logic [16:0]        vlen;
        logic signed [15:0] gl;
        logic signed [15:0] gr;
    } t_mix_cmd;

    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic               playing;
    } t_mix_out;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [TIME_W-1:0] i_cfg_data = '0;

    svmix_in_if  in_ch ();
    svmix_out_if out_ch ();

    scheduled_voice_sample_mixer u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (in_ch),
        .o_result    (out_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // Mixer shadow state
    // ---------------------------------------------------------------
    logic signed [15:0] mem_shadow [0:65535];
    bit                 mem_known  [0:65535];
    logic               v_on    [NVOICE];
    longint             v_start [NVOICE];
    longint             v_len   [NVOICE];
    longint             v_offs  [NVOICE];
    logic [15:0]        v_base  [NVOICE];
    longint             v_clip  [NVOICE];
    longint             v_gl    [NVOICE];
    longint             v_gr    [NVOICE];
    logic [32:0]        timeline;
    bit                 running;
    logic [31:0]        sched_start, sched_frames;

    t_mix_cmd pending_cmds[$];
    t_mix_out mix_expected[$];
    bit       failed;
    bit       no_idle;
    int unsigned cycles;

    // round to nearest (ties up), drop 14 fraction bits, saturate to Q1.15
    function automatic logic signed [15:0] scale_sat(longint acc);
        longint r;
        r = (acc + 64'sd8192) >>> 14;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r[15:0];
    endfunction

    function automatic void mixer_apply(t_mix_cmd c);
        t_mix_out res;
        longint off, idx, al, ar;
        bit any;
        case (c.op)
            OP_WR_SAMPLE: begin
                mem_shadow[c.addr] = c.value;
                mem_known[c.addr] = 1;
            end
            OP_WR_VOICE: begin
                v_on[c.vidx]    = c.ven;
                v_start[c.vidx] = longint'(c.vstart);
                v_len[c.vidx]   = longint'({32'd0, c.vframes});
                v_offs[c.vidx]  = longint'(c.voffs);
                v_base[c.vidx]  = c.vbase;
                v_clip[c.vidx]  = longint'({47'd0, c.vlen});
                v_gl[c.vidx]    = longint'(c.gl);
                v_gr[c.vidx]    = longint'(c.gr);
            end
            OP_START: begin
                any = 0;
                for (int i = 0; i < NVOICE; i++) if (v_on[i]) any = 1;
                if (sched_frames == 0 || !any) begin
                    running = 0;
                end else begin
                    timeline = {1'b0, sched_start};
                    running = 1;
                end
            end
            default: begin
                res = '0;
                if (running) begin
                    al = 0;
                    ar = 0;
                    off = longint'({31'd0, timeline}) - longint'({32'd0, sched_start});
                    if (off >= 0 && off < longint'({32'd0, sched_frames})) begin
                        for (int i = 0; i < NVOICE; i++) begin
                            if (!v_on[i]) continue;
                            if (off < v_start[i] || off >= v_start[i] + v_len[i]) continue;
                            idx = v_offs[i] + (off - v_start[i]);
                            if (idx < 0 || idx >= v_clip[i]) continue;
                            idx = (idx + v_base[i]) % 65536;
                            al += longint'(mem_shadow[idx]) * v_gl[i];
                            ar += longint'(mem_shadow[idx]) * v_gr[i];
                        end
                    end
                    res.left = scale_sat(al);
                    res.right = scale_sat(ar);
                    timeline = timeline + 1;
                    if ({31'd0, timeline} >= longint'(sched_start) + longint'(sched_frames))
                        running = 0;
                    res.playing = running;
                end
                mix_expected.push_back(res);
            end
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Driver: idles in random bursts until the last part of the run
    // ---------------------------------------------------------------
    int in_gap;
    t_mix_cmd cur;
    initial begin
        in_ch.valid = 1'b0;
        {in_ch.opcode, in_ch.sample_address, in_ch.sample_value, in_ch.voice_index,
         in_ch.voice_enable, in_ch.voice_render_start, in_ch.voice_frames,
         in_ch.voice_clip_offset, in_ch.voice_clip_base, in_ch.voice_clip_length,
         in_ch.voice_gain_left, in_ch.voice_gain_right} = '0;
        out_ch.ready = 1'b0;
        in_gap = 0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (!in_ch.valid || in_ch.ready) begin
                if (in_ch.valid) mixer_apply(cur);
                if (in_gap > 0) begin
                    in_gap <= in_gap - 1;
                    in_ch.valid <= 1'b0;
                end else if (pending_cmds.size() > 0) begin
                    cur = pending_cmds.pop_front();
                    in_ch.valid              <= 1'b1;
                    in_ch.opcode             <= cur.op;
                    in_ch.sample_address     <= cur.addr;
                    in_ch.sample_value       <= cur.value;
                    in_ch.voice_index        <= cur.vidx;
                    in_ch.voice_enable       <= cur.ven;
                    in_ch.voice_render_start <= cur.vstart;
                    in_ch.voice_frames       <= cur.vframes;
                    in_ch.voice_clip_offset  <= cur.voffs;
                    in_ch.voice_clip_base    <= cur.vbase;
                    in_ch.voice_clip_length  <= cur.vlen;
                    in_ch.voice_gain_left    <= cur.gl;
                    in_ch.voice_gain_right   <= cur.gr;
                    if (!no_idle && $urandom_range(0, 5) == 0)
                        in_gap <= $urandom_range(1, 11);
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Monitor: checks results in order, stalls in random bursts
    // ---------------------------------------------------------------
    int out_gap = 0;
    t_mix_out want;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                if (mix_expected.size() == 0) begin
                    $error("result with nothing expected");
                    failed = 1;
                end else begin
                    want = mix_expected.pop_front();
                    if (out_ch.left_sample !== want.left) begin
                        $error("left_sample expected %0d got %0d", want.left,
                               out_ch.left_sample);
                        failed = 1;
                    end
                    if (out_ch.right_sample !== want.right) begin
                        $error("right_sample expected %0d got %0d", want.right,
                               out_ch.right_sample);
                        failed = 1;
                    end
                    if (out_ch.playing !== want.playing) begin
                        $error("playing expected %0d got %0d", want.playing,
                               out_ch.playing);
                        failed = 1;
                    end
                end
            end
            if (out_gap > 0) begin
                out_gap <= out_gap - 1;
                out_ch.ready <= 1'b0;
            end else if (!no_idle && $urandom_range(0, 7) == 0) begin
                out_gap <= $urandom_range(1, 11) - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("[scheduled_voice_sample_mixer] ERROR");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    function automatic t_mix_cmd rand_cmd(t_opcode op);
        t_mix_cmd c;
        c.op      = op;
        c.addr    = 16'($urandom);
        c.value   = 16'($urandom);
        c.vidx    = 3'($urandom);
        c.ven     = 1'($urandom);
        c.vstart  = $urandom;
        c.vframes = $urandom;
        c.voffs   = $urandom;
        c.vbase   = 16'($urandom);
        c.vlen    = 17'($urandom_range(0, 65536));
        c.gl      = 16'($urandom);
        c.gr      = 16'($urandom);
        return c;
    endfunction

    task automatic push_sample(int a, int v);
        t_mix_cmd c;
        c = rand_cmd(OP_WR_SAMPLE);
        c.addr = 16'(a);
        c.value = 16'(v);
        pending_cmds.push_back(c);
    endtask

    // voice whose clip stays inside already written memory
    task automatic push_voice(int v, bit en, int rs, int fr, int co, int base, int len,
                              int gl, int gr);
        t_mix_cmd c;
        c = rand_cmd(OP_WR_VOICE);
        c.vidx = 3'(v); c.ven = en; c.vstart = rs; c.vframes = fr; c.voffs = co;
        c.vbase = 16'(base); c.vlen = 17'(len); c.gl = 16'(gl); c.gr = 16'(gr);
        pending_cmds.push_back(c);
    endtask

    task automatic push_op(t_opcode op);
        pending_cmds.push_back(rand_cmd(op));
    endtask

    task automatic wait_idle();
        while (pending_cmds.size() > 0 || in_ch.valid || mix_expected.size() > 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_SCHED_START) sched_start = val; else sched_frames = val;
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    int base, len;
    initial begin
        failed = 0;
        no_idle = 0;
        cycles = 0;
        timeline = '0;
        running = 0;
        sched_start = '0;
        sched_frames = '0;
        for (int i = 0; i < NVOICE; i++) begin
            v_on[i] = 0; v_start[i] = 0; v_len[i] = 0; v_offs[i] = 0;
            v_base[i] = 0; v_clip[i] = 0; v_gl[i] = 0; v_gr[i] = 0;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Clip area: low 64 words plus the top 16 for the address wrap.
        for (int a = 0; a < 64; a++) push_sample(a, $urandom);
        for (int a = 65520; a < 65536; a++) push_sample(a, $urandom);

        // Directed: tick while stopped, refused start (no voice, then no frames).
        push_op(OP_TICK);
        push_op(OP_START);
        push_op(OP_TICK);
        push_sample(0, 32767);
        push_sample(1, -32768);
        wait_idle();
        write_cfg(CFG_SCHED_START, 32'd0);
        write_cfg(CFG_SCHED_FRAMES, 32'd0);
        // full-scale gains saturate both ways; voice 7 wraps the clip over the top
        push_voice(0, 1, 0, 4, 0, 0, 2, 32767, -32768);
        push_voice(1, 1, 1, 2, 0, 0, 2, 32767, 32767);
        push_voice(7, 1, 0, 6, -1, 65534, 5, 16384, -16384);
        push_op(OP_START);
        push_op(OP_TICK);
        wait_idle();
        write_cfg(CFG_SCHED_FRAMES, 32'd6);
        push_op(OP_START);
        repeat (8) push_op(OP_TICK);
        wait_idle();
        // top end of the timeline
        write_cfg(CFG_SCHED_START, 32'hffff_fffe);
        write_cfg(CFG_SCHED_FRAMES, 32'hffff_ffff);
        push_op(OP_START);
        repeat (4) push_op(OP_TICK);
        wait_idle();
        // disable all voices: start refused
        for (int v = 0; v < NVOICE; v++) push_voice(v, 0, 0, 0, 0, 0, 0, 0, 0);
        push_op(OP_START);
        push_op(OP_TICK);
        wait_idle();

        // Random phases: voices into written memory, then a run of mostly ticks with some sample writes and starts.
        for (int ph = 0; ph < 14; ph++) begin
            if (ph == 11) no_idle = 1;
            write_cfg(CFG_SCHED_START, (ph % 4 == 3) ? 32'hffff_ff00 + $urandom_range(0, 255)
                                                     : $urandom);
            write_cfg(CFG_SCHED_FRAMES, (ph % 5 == 4) ? 32'hffff_ffff : $urandom_range(1, 40));
            for (int k = 0; k < 10; k++) begin
                if ($urandom_range(0, 1)) begin
                    base = $urandom_range(0, 63);
                    len  = $urandom_range(0, 64 - base);
                end else begin
                    base = $urandom_range(65520, 65535);
                    len  = $urandom_range(0, 65536 + 64 - base);
                end
                push_voice($urandom_range(0, 7), $urandom_range(0, 3) != 0,
                           $urandom_range(0, 10) - 3, $urandom_range(0, 30),
                           $urandom_range(0, 10) - 3, base, len, $urandom, $urandom);
            end
            if (ph % 3 == 0) push_sample($urandom_range(0, 63), $urandom);
            push_op(OP_START);
            for (int k = 0; k < 55; k++) begin
                if ($urandom_range(0, 15) == 0) push_sample($urandom_range(0, 63), $urandom);
                else if ($urandom_range(0, 30) == 0) push_op(OP_START);
                else push_op(OP_TICK);
            end
            wait_idle();
        end

        if (!failed) begin
            $display("[scheduled_voice_sample_mixer] OK");
        end else begin
            $display("[scheduled_voice_sample_mixer] ERROR");
        end
        $finish;
    end

endmodule
